// ===== hw/rtl/mi3_pkg.sv =====
// Shared constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
package mi3_pkg;
  localparam int MAT_DIM     = 3;
  localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
endpackage

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// 3x3 fixed-point matrix inverse by the adjugate method, fully pipelined.
//
// Input channel: in_valid / in_stall with nine signed matrix entries m_rXcY,
// each WORD_BITS wide with FRAC_BITS fraction bits. Output channel:
// out_valid / out_stall with nine inverse entries, det_value and singular.
// A beat moves when valid is high and stall is low.
// Throughput: one matrix per cycle while in_stall is low. The divider
// resolves one quotient bit per stage over WORD_BITS + 1 stages, behind
// two adjugate stages and four determinant stages.
// A zero determinant sets singular and forces inverse and det_value to zero.
// Results round half away from zero and saturate to the word range.
// Reset (rst, synchronous) empties the pipeline and the output registers.
// When the receiver stalls, the output register holds its beat and one
// more beat lands in a skid register; in_stall rises only while that skid
// register is full, so the pipeline freezes as a whole and drops nothing.
`timescale 1ns / 1ps
module matrix_inverse_3x3 #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] m_r0c0,
  input  logic signed [WORD_BITS-1:0] m_r0c1,
  input  logic signed [WORD_BITS-1:0] m_r0c2,
  input  logic signed [WORD_BITS-1:0] m_r1c0,
  input  logic signed [WORD_BITS-1:0] m_r1c1,
  input  logic signed [WORD_BITS-1:0] m_r1c2,
  input  logic signed [WORD_BITS-1:0] m_r2c0,
  input  logic signed [WORD_BITS-1:0] m_r2c1,
  input  logic signed [WORD_BITS-1:0] m_r2c2,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] inv_r0c0,
  output logic signed [WORD_BITS-1:0] inv_r0c1,
  output logic signed [WORD_BITS-1:0] inv_r0c2,
  output logic signed [WORD_BITS-1:0] inv_r1c0,
  output logic signed [WORD_BITS-1:0] inv_r1c1,
  output logic signed [WORD_BITS-1:0] inv_r1c2,
  output logic signed [WORD_BITS-1:0] inv_r2c0,
  output logic signed [WORD_BITS-1:0] inv_r2c1,
  output logic signed [WORD_BITS-1:0] inv_r2c2,
  output logic signed [WORD_BITS-1:0] det_value,
  output logic                        singular
);
  import mi3_pkg::*;

  localparam int W       = WORD_BITS;
  localparam int AW      = 2 * W + 1;
  localparam int MW      = 3 * W + 1;
  localparam int QB      = W + 1;
  localparam int LAT_DIV = QB + 4;
  localparam int DET_LAT = 4;
  localparam int TOT     = 2 + DET_LAT + LAT_DIV;

  logic                 en;
  logic                 skid_v;
  logic                 take;
  logic                 lv;
  logic [TOT-1:0]       vpipe;

  logic signed [W-1:0]  m    [MAT_ENTRIES];
  logic signed [AW-1:0] adj  [MAT_ENTRIES];
  logic signed [W-1:0]  mrow [MAT_DIM];
  logic signed [AW-1:0] cof  [MAT_DIM];
  logic signed [AW-1:0] adjd [DET_LAT][MAT_ENTRIES];
  logic [MW-1:0]        dmag;
  logic                 dneg;
  logic                 dzero;
  logic signed [W-1:0]  qv   [MAT_ENTRIES];

  logic [MW:0]          dr1;
  logic                 dn1;
  logic [MW:0]          dsh;
  logic [MW:0]          dlim;
  logic [MW:0]          dm;
  logic signed [W-1:0]  dq   [LAT_DIV-1];
  logic                 zd   [LAT_DIV];

  logic signed [W-1:0]  ninv [MAT_ENTRIES];
  logic signed [W-1:0]  ndet;
  logic signed [W-1:0]  oinv [MAT_ENTRIES];
  logic signed [W-1:0]  odet;
  logic                 osing;
  logic signed [W-1:0]  sinv [MAT_ENTRIES];
  logic signed [W-1:0]  sdet;
  logic                 ssing;

  // Freeze the whole pipeline only while the skid register holds a beat
  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign take     = out_valid && !out_stall;
  assign lv       = vpipe[TOT-1] && en;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOT-2:0], in_valid};
    end
  end

  assign m[0] = m_r0c0;
  assign m[1] = m_r0c1;
  assign m[2] = m_r0c2;
  assign m[3] = m_r1c0;
  assign m[4] = m_r1c1;
  assign m[5] = m_r1c2;
  assign m[6] = m_r2c0;
  assign m[7] = m_r2c1;
  assign m[8] = m_r2c2;

  mi3_adj #(.WORD_BITS(W)) u_adj (
    .clk  (clk),
    .en   (en),
    .m    (m),
    .adj  (adj),
    .mrow (mrow)
  );

  // First-row cofactors sit in the first column of the adjugate
  for (genvar j = 0; j < MAT_DIM; j++) begin : g_cof
    assign cof[j] = adj[j * MAT_DIM];
  end

  mi3_det #(.WORD_BITS(W)) u_det (
    .clk   (clk),
    .en    (en),
    .mrow  (mrow),
    .cof   (cof),
    .dmag  (dmag),
    .dneg  (dneg),
    .dzero (dzero)
  );

  // Hold the adjugate until the determinant is ready
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MAT_ENTRIES; k++) begin
        adjd[0][k] <= adj[k];
        for (int s = 1; s < DET_LAT; s++) begin
          adjd[s][k] <= adjd[s-1][k];
        end
      end
    end
  end

  for (genvar k = 0; k < MAT_ENTRIES; k++) begin : g_div
    mi3_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .adj  (adjd[DET_LAT-1][k]),
      .dmag (dmag),
      .dneg (dneg),
      .q    (qv[k])
    );
  end

  // Round and clamp the determinant, then delay it to match the dividers
  assign dsh  = dr1 >> (2 * FRAC_BITS);
  assign dlim = ((MW+1)'(1) << (W - 1)) - (MW+1)'(!dn1);
  assign dm   = (dsh > dlim) ? dlim : dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      dr1   <= {1'b0, dmag} + ((MW+1)'(1) << (2 * FRAC_BITS - 1));
      dn1   <= dneg;
      dq[0] <= dn1 ? -dm[W-1:0] : dm[W-1:0];
      for (int s = 1; s < LAT_DIV - 1; s++) begin
        dq[s] <= dq[s-1];
      end
      zd[0] <= dzero;
      for (int s = 1; s < LAT_DIV; s++) begin
        zd[s] <= zd[s-1];
      end
    end
  end

  // Zero everything on a singular matrix
  always_comb begin
    for (int k = 0; k < MAT_ENTRIES; k++) begin
      ninv[k] = zd[LAT_DIV-1] ? '0 : qv[k];
    end
    ndet = zd[LAT_DIV-1] ? '0 : dq[LAT_DIV-2];
  end

  // Output register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (lv) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid register data
  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        oinv  <= sinv;
        odet  <= sdet;
        osing <= ssing;
      end
    end else if (lv) begin
      if (!out_valid || take) begin
        oinv  <= ninv;
        odet  <= ndet;
        osing <= zd[LAT_DIV-1];
      end else begin
        sinv  <= ninv;
        sdet  <= ndet;
        ssing <= zd[LAT_DIV-1];
      end
    end
  end

  assign inv_r0c0  = oinv[0];
  assign inv_r0c1  = oinv[1];
  assign inv_r0c2  = oinv[2];
  assign inv_r1c0  = oinv[3];
  assign inv_r1c1  = oinv[4];
  assign inv_r1c2  = oinv[5];
  assign inv_r2c0  = oinv[6];
  assign inv_r2c1  = oinv[7];
  assign inv_r2c2  = oinv[8];
  assign det_value = odet;
  assign singular  = osing;
endmodule

// ===== hw/rtl/mi3_adj.sv =====
// Adjugate stages: cofactor products, then differences.
`timescale 1ns / 1ps
module mi3_adj #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WORD_BITS-1:0] m    [mi3_pkg::MAT_ENTRIES],
  output logic signed [2*WORD_BITS:0] adj  [mi3_pkg::MAT_ENTRIES],
  output logic signed [WORD_BITS-1:0] mrow [mi3_pkg::MAT_DIM]
);
  import mi3_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * W + 1;

  // Adjugate entry k = m[IA]*m[IB] - m[IC]*m[ID]
  localparam int IA [MAT_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IB [MAT_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IC [MAT_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ID [MAT_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [2*W-1:0] pa [MAT_ENTRIES];
  logic signed [2*W-1:0] pb [MAT_ENTRIES];
  logic signed [W-1:0]   row1 [MAT_DIM];

  for (genvar k = 0; k < MAT_ENTRIES; k++) begin : g_cof
    // Stage one: the two products of each cofactor
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k] <= m[IA[k]] * m[IB[k]];
        pb[k] <= m[IC[k]] * m[ID[k]];
      end
    end
    // Stage two: take the difference at full width
    always_ff @(posedge clk) begin
      if (en) begin
        adj[k] <= AW'(pa[k]) - AW'(pb[k]);
      end
    end
  end

  // Carry the first row along for the determinant
  for (genvar j = 0; j < MAT_DIM; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        row1[j] <= m[j];
        mrow[j] <= row1[j];
      end
    end
  end
endmodule

// ===== hw/rtl/mi3_det.sv =====
// Determinant stages: split products, partial sums, combine, magnitude.
`timescale 1ns / 1ps
module mi3_det #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [WORD_BITS-1:0] mrow [mi3_pkg::MAT_DIM],
  input  logic signed [2*WORD_BITS:0] cof  [mi3_pkg::MAT_DIM],
  output logic        [3*WORD_BITS:0] dmag,
  output logic                        dneg,
  output logic                        dzero
);
  import mi3_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = 2 * W + 1;
  localparam int DW = 3 * W + 2;
  localparam int MW = 3 * W + 1;

  logic signed [2*W:0]  ph [MAT_DIM];
  logic signed [2*W:0]  pl [MAT_DIM];
  logic signed [DW-1:0] sh;
  logic signed [DW-1:0] sl;
  logic signed [DW-1:0] det;

  // Multiply row entries by the upper and lower halves of each cofactor
  for (genvar j = 0; j < MAT_DIM; j++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        ph[j] <= mrow[j] * $signed(cof[j][AW-1:W]);
        pl[j] <= mrow[j] * $signed({1'b0, cof[j][W-1:0]});
      end
    end
  end

  // Sum halves, combine, then split into sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      sh    <= DW'(ph[0]) + DW'(ph[1]) + DW'(ph[2]);
      sl    <= DW'(pl[0]) + DW'(pl[1]) + DW'(pl[2]);
      det   <= (sh <<< W) + sl;
      dneg  <= det[DW-1];
      dzero <= (det == '0);
      dmag  <= det[DW-1] ? MW'(-det) : MW'(det);
    end
  end
endmodule

// ===== hw/rtl/mi3_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, round, saturate.
`timescale 1ns / 1ps
module mi3_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [2*WORD_BITS:0] adj,
  input  logic        [3*WORD_BITS:0] dmag,
  input  logic                        dneg,
  output logic signed [WORD_BITS-1:0] q
);
  localparam int W  = WORD_BITS;
  localparam int AW = 2 * W + 1;
  localparam int MW = 3 * W + 1;
  localparam int QB = W + 1;
  localparam int NW = AW + 2 * FRAC_BITS;
  localparam int CW = (NW > MW + QB) ? NW : MW + QB;

  logic [AW-1:0] amag;
  logic [CW-1:0] num1;
  logic [MW-1:0] d1;
  logic          n1;

  logic [CW-1:0] rem [QB+1];
  logic [QB-1:0] qa  [QB+1];
  logic [MW-1:0] dd  [QB+1];
  logic          nn  [QB+1];
  logic          ov  [QB+1];

  logic [QB:0]   qr;
  logic          nr;
  logic          orr;
  logic          up;
  logic [QB:0]   lim;
  logic [QB:0]   mg;

  assign amag = adj[AW-1] ? AW'(-adj) : AW'(adj);

  // Scale the numerator magnitude and fix the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= {{(CW-AW){1'b0}}, amag} << (2 * FRAC_BITS);
      d1   <= dmag;
      n1   <= adj[AW-1] ^ dneg;
    end
  end

  // Flag quotients that cannot fit the bit stages
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num1;
      qa[0]  <= '0;
      dd[0]  <= d1;
      nn[0]  <= n1;
      ov[0]  <= (num1 >= ({{(CW-MW){1'b0}}, d1} << QB));
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int K = QB - 1 - i;
    logic [CW-1:0] ds;
    logic          ge;
    assign ds = {{(CW-MW){1'b0}}, dd[i]} << K;
    assign ge = (rem[i] >= ds);
    // Try the shifted divisor, keep the bit when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? rem[i] - ds : rem[i];
        qa[i+1]  <= {qa[i][QB-2:0], ge};
        dd[i+1]  <= dd[i];
        nn[i+1]  <= nn[i];
        ov[i+1]  <= ov[i];
      end
    end
  end

  // Round half away from zero on the remainder
  assign up = ({rem[QB], 1'b0} >= {{(CW+1-MW){1'b0}}, dd[QB]});

  always_ff @(posedge clk) begin
    if (en) begin
      qr  <= {1'b0, qa[QB]} + (QB+1)'(up);
      nr  <= nn[QB];
      orr <= ov[QB];
    end
  end

  // Clamp to the signed output range and apply the sign
  assign lim = ((QB+1)'(1) << (W - 1)) - (QB+1)'(!nr);
  assign mg  = (orr || (qr > lim)) ? lim : qr;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nr ? -mg[W-1:0] : mg[W-1:0];
    end
  end
endmodule

// ===== hw/rtl/mi3_chk.sv =====
// Port-level checks for the matrix inverse block, bound to the top level.
`timescale 1ns / 1ps
module mi3_chk #(
  parameter int WORD_BITS = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [WORD_BITS-1:0] inv_r0c0,
  input logic signed [WORD_BITS-1:0] inv_r1c1,
  input logic signed [WORD_BITS-1:0] inv_r2c2,
  input logic signed [WORD_BITS-1:0] det_value,
  input logic                        singular
);
  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(det_value) && $stable(singular))
    else $error("stalled output beat dropped or changed");

  // Stall the input only after the output has been stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without an output stall");

  // A pending skid beat implies a visible output beat
  a_stall_valid: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output beat");

  // Drive zeros on a singular matrix (diagonal entries and det_value checked)
  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0
                              && det_value == '0)
    else $error("singular result carries nonzero values");
endmodule

bind matrix_inverse_3x3 mi3_chk #(.WORD_BITS(WORD_BITS)) u_mi3_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .inv_r0c0  (inv_r0c0),
  .inv_r1c1  (inv_r1c1),
  .inv_r2c2  (inv_r2c2),
  .det_value (det_value),
  .singular  (singular)
);

// ===== bench/mi3_checker.sv =====
// Checker for the 3x3 matrix inverse: predicts each result and compares it.
`timescale 1ns / 1ps
module mi3_checker #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] m_ent [mi3_pkg::MAT_ENTRIES],
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [WORD_BITS-1:0] inv_ent [mi3_pkg::MAT_ENTRIES],
  input  logic signed [WORD_BITS-1:0] det_value,
  input  logic                        singular,
  output int                          fail_count,
  output int                          pending,
  output int                          singular_seen
);
  import mi3_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef struct {
    logic signed [WORD_BITS-1:0] inv [MAT_ENTRIES];
    logic signed [WORD_BITS-1:0] det;
    logic                        sing;
  } inverse_t;

  inverse_t expected_inverses[$];

  // Clamp a signed wide value to the word range.
  function automatic logic signed [WORD_BITS-1:0] clamp_word(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -(wide_t'(1) <<< (WORD_BITS - 1));
    if (v > hi) return hi[WORD_BITS-1:0];
    if (v < lo) return lo[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  // Magnitude quotient rounded half away from zero, then signed.
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t an, ad, q, r;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = an / ad;
    r = an % ad;
    if ((r <<< 1) >= ad) q = q + 1;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic inverse_t predict_inverse(logic signed [WORD_BITS-1:0] m [MAT_ENTRIES]);
    inverse_t res;
    wide_t a [MAT_ENTRIES];
    wide_t adj [MAT_ENTRIES];
    wide_t det;
    for (int k = 0; k < MAT_ENTRIES; k++) a[k] = m[k];
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    res.sing = (det == 0);
    for (int k = 0; k < MAT_ENTRIES; k++)
      res.inv[k] = res.sing ? '0 : clamp_word(div_round(adj[k] <<< (2 * FRAC_BITS), det));
    res.det = res.sing ? '0 : clamp_word(div_round(det, wide_t'(1) <<< (2 * FRAC_BITS)));
    return res;
  endfunction

  assign pending = expected_inverses.size();

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    inverse_t want;
    int errs;
    errs = 0;
    if (rst) begin
      expected_inverses.delete();
      fail_count <= 0;
      singular_seen <= 0;
    end else begin
      if (in_valid && !in_stall) expected_inverses.push_back(predict_inverse(m_ent));
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          errs++;
        end else begin
          want = expected_inverses.pop_front();
          if (singular) singular_seen <= singular_seen + 1;
          if (want.sing !== singular || want.det !== det_value) begin
            $display("%0t: det/singular expected %0d/%0b actual %0d/%0b",
                     $time, want.det, want.sing, det_value, singular);
            errs++;
          end
          for (int k = 0; k < MAT_ENTRIES; k++)
            if (want.inv[k] !== inv_ent[k]) begin
              $display("%0t: inverse entry %0d expected %0d actual %0d",
                       $time, k, want.inv[k], inv_ent[k]);
              errs++;
            end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== bench/matrix_inverse_3x3_test.sv =====
// Top of the 3x3 matrix inverse testbench: stimulus, block and verdict.
`timescale 1ns / 1ps
module matrix_inverse_3x3_test;
  import mi3_pkg::*;
  localparam int WB = 32;
  localparam int LATENCY = WB + 12;
  localparam int RANDOM_MATS = 800;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, singular;
  logic signed [WB-1:0] m_ent [MAT_ENTRIES];
  logic signed [WB-1:0] inv_ent [MAT_ENTRIES];
  logic signed [WB-1:0] det_value;
  int fail_count, pending, singular_seen;
  int matrices_sent = 0;
  longint cycle = 0;
  bit calm = 0;

  initial for (int k = 0; k < MAT_ENTRIES; k++) m_ent[k] = '0;

  always #5 clk = ~clk;

  matrix_inverse_3x3 #(.WORD_BITS(WB), .FRAC_BITS(16)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .m_r0c0(m_ent[0]), .m_r0c1(m_ent[1]), .m_r0c2(m_ent[2]),
    .m_r1c0(m_ent[3]), .m_r1c1(m_ent[4]), .m_r1c2(m_ent[5]),
    .m_r2c0(m_ent[6]), .m_r2c1(m_ent[7]), .m_r2c2(m_ent[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv_r0c0(inv_ent[0]), .inv_r0c1(inv_ent[1]), .inv_r0c2(inv_ent[2]),
    .inv_r1c0(inv_ent[3]), .inv_r1c1(inv_ent[4]), .inv_r1c2(inv_ent[5]),
    .inv_r2c0(inv_ent[6]), .inv_r2c1(inv_ent[7]), .inv_r2c2(inv_ent[8]),
    .det_value(det_value), .singular(singular)
  );

  mi3_checker #(.WORD_BITS(WB), .FRAC_BITS(16)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .m_ent(m_ent),
    .out_valid(out_valid), .out_stall(out_stall), .inv_ent(inv_ent),
    .det_value(det_value), .singular(singular), .fail_count(fail_count),
    .pending(pending), .singular_seen(singular_seen)
  );

  // Stall the output at random, except in the calm stretch.
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 18);

  // End the run on a hung pipeline.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pick one entry: extremes, small Q16.16 values, or raw bits.
  function automatic logic signed [WB-1:0] pick_entry();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3, 4, 5: return $signed($urandom_range(32'h6_0000)) - 32'sh3_0000;
      6, 7: return $signed($urandom_range(32'h100)) - 32'sh80;
      default: return $urandom;
    endcase
  endfunction

  // Present one matrix and hold it until the beat is taken.
  task automatic send_matrix(logic signed [WB-1:0] mat [MAT_ENTRIES]);
    for (int k = 0; k < MAT_ENTRIES; k++) m_ent[k] <= mat[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    matrices_sent++;
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    logic signed [WB-1:0] mat [MAT_ENTRIES];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, scaled, singular, extremes, tiny determinant.
    for (int d = 0; d < 14; d++) begin
      for (int k = 0; k < MAT_ENTRIES; k++) mat[k] = '0;
      case (d)
        0: begin mat[0] = 32'sh1_0000; mat[4] = 32'sh1_0000; mat[8] = 32'sh1_0000; end
        1: begin mat[0] = 32'sh2_0000; mat[4] = -32'sh4_0000; mat[8] = 32'sh0_8000; end
        2: ;
        3: for (int k = 0; k < MAT_ENTRIES; k++) mat[k] = 32'sh1_0000;
        4: for (int k = 0; k < MAT_ENTRIES; k++) mat[k] = 32'sh8000_0000;
        5: begin mat[0] = 32'sh7fff_ffff; mat[4] = 32'sh7fff_ffff; mat[8] = 32'sh7fff_ffff; end
        6: begin mat[0] = 32'sh8000_0000; mat[4] = 32'sh8000_0000; mat[8] = 32'sh8000_0000; end
        7: begin mat[0] = 1; mat[4] = 1; mat[8] = 1; end
        8: begin mat[0] = 32'sh100; mat[4] = 32'sh100; mat[8] = 32'sh100; end
        9: begin mat[2] = 32'sh1_0000; mat[4] = 32'sh1_0000; mat[6] = 32'sh1_0000; end
        10: begin mat[0] = 32'sh3_0000; mat[1] = 32'sh1_0000; mat[3] = 32'sh6_0000;
                  mat[4] = 32'sh2_0000; mat[8] = 32'sh1_0000; end
        11: begin mat[0] = 32'sh8000; mat[4] = 32'sh8000; mat[8] = 32'sh8000; end
        12: begin mat[0] = 32'sh7fff_ffff; mat[1] = 32'sh8000_0000; mat[3] = 32'sh8000_0000;
                  mat[4] = 32'sh7fff_ffff; mat[8] = -32'sh1; end
        default: for (int k = 0; k < MAT_ENTRIES; k++) mat[k] = 32'hffff_ffff;
      endcase
      send_matrix(mat);
    end

    // Random: diagonal-heavy, singular by repeated rows, and free-form.
    for (int n = 0; n < RANDOM_MATS; n++) begin
      calm = (n >= 300 && n < 400);
      for (int k = 0; k < MAT_ENTRIES; k++) mat[k] = pick_entry();
      case ($urandom_range(5))
        0: begin mat[1] = 0; mat[2] = 0; mat[3] = 0; mat[5] = 0; mat[6] = 0; mat[7] = 0; end
        1: for (int k = 0; k < MAT_DIM; k++) mat[6 + k] = mat[k];
        default: ;
      endcase
      send_matrix(mat);
      // Drain the pipeline once mid-run.
      if (n == 500) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d matrices (%0d came back singular) with random idles and stalls.",
             matrices_sent, singular_seen);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== matrix_inverse_3x3.f =====
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_adj.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_chk.sv
bench/mi3_checker.sv
bench/matrix_inverse_3x3_test.sv
